### rtl/core/hlwt_pkg.sv
package hlwt_pkg;

    // Depth of the finished-word buffer
    localparam int MAX_WORDS = 4;

    // Word counter holds 0..MAX_WORDS, buffer index holds 0..MAX_WORDS-1
    localparam int CNT_W = $clog2(MAX_WORDS + 1);
    localparam int IDX_W = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;

    localparam int WORD_W   = 32;
    localparam int CHAR_W   = 8;
    localparam int NIBBLE_W = 4;
    localparam int DIGIT_W  = 3;

endpackage

### rtl/core/hlwt_if.sv
// Character channel: one ASCII character or a line end per transfer
interface hlwt_in_if;
    logic                           valid;
    logic                           ready;
    logic [hlwt_pkg::CHAR_W-1:0]    character;
    logic                           line_end;

    modport source (output valid, output character, output line_end, input ready);
    modport sink   (input valid, input character, input line_end, output ready);
endinterface

// Word channel: one parsed word per transfer
interface hlwt_out_if;
    logic                           valid;
    logic                           ready;
    logic [hlwt_pkg::WORD_W-1:0]    word;
    logic                           last_word;
    logic                           overflowed;

    modport source (output valid, output word, output last_word, output overflowed,
                    input ready);
    modport sink   (input valid, input word, input last_word, input overflowed,
                    output ready);
endinterface

### rtl/core/hex_line_word_tokenizer.sv
// Hex line word tokenizer. Characters of a line arrive one per transfer on in_ch;
// whitespace is skipped, hex digits (either case) are packed top nibble first into
// 32-bit words of 8 digits, or, with alternate_mode set, 8 and 4 digits in turn
// (a 4-digit word sits in the upper half). Finished words go into a small
// two-port buffer RAM of MAX_WORDS entries with registered read data. A line-end
// transfer releases the buffered words on out_ch, the final one flagged last_word,
// unless a non-hex character rejected the line; a trailing partial word is
// dropped, words beyond MAX_WORDS are dropped and reported by overflowed on every
// word of the line. in_ch is ready only while no words are being released: a line
// end releasing words stalls in_ch until the last one is taken, each word passing
// through a buffer read state (S_READ) and an output state (S_SHOW) that waits
// for out_ch.ready. alternate_mode is written via cfg_we/cfg_wdata.
module hex_line_word_tokenizer (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic                cfg_wdata,
    hlwt_in_if.sink             in_ch,
    hlwt_out_if.source          out_ch
);
    import hlwt_pkg::*;

    localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
    localparam logic [CHAR_W-1:0] CH_WS_LO  = 8'h09;
    localparam logic [CHAR_W-1:0] CH_WS_HI  = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_DIG_LO = 8'h30;
    localparam logic [CHAR_W-1:0] CH_DIG_HI = 8'h39;
    localparam logic [CHAR_W-1:0] CH_LC_LO  = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LC_HI  = 8'h66;
    localparam logic [CHAR_W-1:0] CH_UC_LO  = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UC_HI  = 8'h46;

    localparam logic [DIGIT_W:0] LIMIT_LONG  = 4'd8;
    localparam logic [DIGIT_W:0] LIMIT_SHORT = 4'd4;

    typedef enum logic [1:0] {
        S_RUN,
        S_READ,
        S_SHOW
    } state_t;

    // Decoded character: valid digit flag and nibble value
    typedef struct packed {
        logic                is_hex;
        logic [NIBBLE_W-1:0] value;
    } hex_dec_t;

    function automatic hex_dec_t hex_decode(input logic [CHAR_W-1:0] c);
        hex_dec_t r;
        logic [CHAR_W-1:0] diff;
        r    = '0;
        diff = '0;
        if (c >= CH_DIG_LO && c <= CH_DIG_HI)
        begin
            diff     = c - CH_DIG_LO;
            r.is_hex = 1'b1;
            r.value  = diff[NIBBLE_W-1:0];
        end
        else if (c >= CH_LC_LO && c <= CH_LC_HI)
        begin
            diff     = c - CH_LC_LO + 8'd10;
            r.is_hex = 1'b1;
            r.value  = diff[NIBBLE_W-1:0];
        end
        else if (c >= CH_UC_LO && c <= CH_UC_HI)
        begin
            diff     = c - CH_UC_LO + 8'd10;
            r.is_hex = 1'b1;
            r.value  = diff[NIBBLE_W-1:0];
        end
        return r;
    endfunction

    state_t               state_reg, state_next;
    logic                 alt_mode_reg;
    logic [DIGIT_W-1:0]   digit_count_reg, digit_count_next;
    logic [WORD_W-1:0]    partial_reg, partial_next;
    logic [CNT_W-1:0]     word_count_reg, word_count_next;
    logic                 parity_reg, parity_next;
    logic                 line_bad_reg, line_bad_next;
    logic                 overflow_reg, overflow_next;
    logic [CNT_W-1:0]     drain_total_reg, drain_total_next;
    logic                 drain_ovf_reg, drain_ovf_next;
    logic [IDX_W-1:0]     rd_idx_reg, rd_idx_next;

    // Word buffer RAM
    logic [WORD_W-1:0]    word_mem [MAX_WORDS];
    logic [WORD_W-1:0]    rd_data_reg;
    logic                 mem_we;
    logic [WORD_W-1:0]    mem_wdata;
    logic                 mem_re;

    logic                 in_xfer;
    logic                 out_xfer;
    logic                 is_ws;
    hex_dec_t             dec;
    logic [DIGIT_W:0]     digit_inc;
    logic [DIGIT_W:0]     limit;
    logic [WORD_W-1:0]    partial_new;
    logic                 rd_last;

    assign in_ch.ready = (state_reg == S_RUN);
    assign in_xfer     = in_ch.valid && in_ch.ready;

    assign out_ch.valid      = (state_reg == S_SHOW);
    assign out_ch.word       = rd_data_reg;
    assign out_ch.last_word  = rd_last;
    assign out_ch.overflowed = drain_ovf_reg;
    assign out_xfer          = out_ch.valid && out_ch.ready;

    assign rd_last = ((CNT_W'(rd_idx_reg) + CNT_W'(1)) == drain_total_reg);

    // Character classification and digit packing
    assign is_ws = (in_ch.character == CH_SPACE)
                || (in_ch.character >= CH_WS_LO && in_ch.character <= CH_WS_HI);
    assign dec         = hex_decode(in_ch.character);
    assign digit_inc   = {1'b0, digit_count_reg} + 4'd1;
    assign limit       = (alt_mode_reg && parity_reg) ? LIMIT_SHORT : LIMIT_LONG;
    assign partial_new = partial_reg
                       | ({dec.value, {(WORD_W-NIBBLE_W){1'b0}}} >> {digit_count_reg, 2'b00});

    // Next-state logic
    always_comb
    begin
        state_next       = state_reg;
        digit_count_next = digit_count_reg;
        partial_next     = partial_reg;
        word_count_next  = word_count_reg;
        parity_next      = parity_reg;
        line_bad_next    = line_bad_reg;
        overflow_next    = overflow_reg;
        drain_total_next = drain_total_reg;
        drain_ovf_next   = drain_ovf_reg;
        rd_idx_next      = rd_idx_reg;
        mem_we           = 1'b0;
        mem_wdata        = partial_new;
        mem_re           = 1'b0;

        case (state_reg)
            S_RUN:
            begin
                if (in_xfer && in_ch.line_end)
                begin
                    // release buffered words unless rejected or empty
                    if (!line_bad_reg && word_count_reg != '0)
                    begin
                        drain_total_next = word_count_reg;
                        drain_ovf_next   = overflow_reg;
                        rd_idx_next      = '0;
                        state_next       = S_READ;
                    end
                    digit_count_next = '0;
                    partial_next     = '0;
                    word_count_next  = '0;
                    parity_next      = 1'b0;
                    line_bad_next    = 1'b0;
                    overflow_next    = 1'b0;
                end
                else if (in_xfer && !line_bad_reg && !is_ws)
                begin
                    if (!dec.is_hex)
                    begin
                        line_bad_next = 1'b1;
                    end
                    else if (digit_inc >= limit)
                    begin
                        // word complete: store it or note the drop
                        if (word_count_reg < CNT_W'(MAX_WORDS))
                        begin
                            mem_we          = 1'b1;
                            word_count_next = word_count_reg + CNT_W'(1);
                        end
                        else
                        begin
                            overflow_next = 1'b1;
                        end
                        parity_next      = !parity_reg;
                        digit_count_next = '0;
                        partial_next     = '0;
                    end
                    else
                    begin
                        digit_count_next = digit_inc[DIGIT_W-1:0];
                        partial_next     = partial_new;
                    end
                end
            end
            S_READ:
            begin
                mem_re     = 1'b1;
                state_next = S_SHOW;
            end
            S_SHOW:
            begin
                if (out_xfer)
                begin
                    if (rd_last)
                    begin
                        state_next = S_RUN;
                    end
                    else
                    begin
                        rd_idx_next = rd_idx_reg + IDX_W'(1);
                        state_next  = S_READ;
                    end
                end
            end
            default:
            begin
                state_next = S_RUN;
            end
        endcase
    end

    // State and control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_RUN;
            alt_mode_reg    <= 1'b0;
            digit_count_reg <= '0;
            partial_reg     <= '0;
            word_count_reg  <= '0;
            parity_reg      <= 1'b0;
            line_bad_reg    <= 1'b0;
            overflow_reg    <= 1'b0;
            drain_total_reg <= '0;
            drain_ovf_reg   <= 1'b0;
            rd_idx_reg      <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            digit_count_reg <= digit_count_next;
            partial_reg     <= partial_next;
            word_count_reg  <= word_count_next;
            parity_reg      <= parity_next;
            line_bad_reg    <= line_bad_next;
            overflow_reg    <= overflow_next;
            drain_total_reg <= drain_total_next;
            drain_ovf_reg   <= drain_ovf_next;
            rd_idx_reg      <= rd_idx_next;
            if (cfg_we)
            begin
                alt_mode_reg <= cfg_wdata;
            end
        end
    end

    // Buffer RAM: writes only while parsing, reads only while draining
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            word_mem[word_count_reg[IDX_W-1:0]] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= word_mem[rd_idx_reg];
        end
    end

endmodule
